/* sv/isaac_random_generator_core_defines.svh */
// Assertion macros shared by the generator's RTL files.
`ifndef ISAAC_RANDOM_GENERATOR_CORE_DEFINES_SVH
`define ISAAC_RANDOM_GENERATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define ISAAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ISAAC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ISAAC_ASSERT(lbl, prop, msg)
`define ISAAC_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

/* sv/isaac_pkg.sv */
// Types, constants and the mixing function of the ISAAC generator.
`default_nettype none
package isaac_pkg;

  localparam int unsigned MEM_WORDS_DEF = 256;
  localparam logic [31:0] GOLDEN_RATIO  = 32'h9e37_79b9;

  typedef enum logic [1:0] {
    OP_SEED  = 2'd0,
    OP_INIT  = 2'd1,
    OP_NEXT  = 2'd2,
    OP_REGEN = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MRD_IDX,
    MRD_PART,
    MRD_X,
    MRD_Y
  } mem_rsel_t;

  typedef struct packed {
    logic      latch_in;
    logic      clear;
    logic      seed_wr;
    logic      v_init;
    logic      v_mix;
    logic [2:0] mix_step;
    logic      v_add;
    logic      v_add_res;
    logic      v_write;
    logic      gen_start;
    logic      acc_shift;
    logic      x_load;
    logic      acc_add;
    logic      y_write;
    logic      res_gen;
    mem_rsel_t mem_rsel;
    logic      res_rd_wl;
    logic      wl_full;
    logic      wl_dec;
    logic      out_load;
  } ctl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic mix_seed;
    logic wl_zero;
    logic out_free;
  } dp_stat_t;

  // One line of the eight-word golden-ratio mix.
  function automatic logic [7:0][31:0] mix_line(input logic [7:0][31:0] v,
                                                input logic [2:0] m);
    logic [2:0]        a;
    logic [2:0]        b;
    logic [2:0]        c;
    logic [2:0]        d;
    logic [31:0]       sh;
    logic [7:0][31:0]  r;
    a = m;
    b = m + 3'd1;
    c = m + 3'd2;
    d = m + 3'd3;
    r = v;
    case (m)
      3'd0: sh = r[b] << 11;
      3'd1: sh = r[b] >> 2;
      3'd2: sh = r[b] << 8;
      3'd3: sh = r[b] >> 16;
      3'd4: sh = r[b] << 10;
      3'd5: sh = r[b] >> 4;
      3'd6: sh = r[b] << 8;
      default: sh = r[b] >> 9;
    endcase
    r[a] = r[a] ^ sh;
    r[d] = r[d] + r[a];
    r[b] = r[b] + r[c];
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/isaac_if.sv */
// Valid/ready channel interfaces for request and result transactions.
`default_nettype none
interface isaac_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] seed_word;
  logic [7:0]  seed_index;
  logic        mix_seed;

  modport source (output valid, op, seed_word, seed_index, mix_seed, input ready);
  modport sink (input valid, op, seed_word, seed_index, mix_seed, output ready);
endinterface

interface isaac_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] rand_word;

  modport source (output valid, rand_word, input ready);
  modport sink (input valid, rand_word, output ready);
endinterface
`default_nettype wire

/* sv/isaac_ram.sv */
// Single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module isaac_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* sv/isaac_ctrl.sv */
// Sequencer for seed writes, initialization, block generation and word reads.
`default_nettype none
`include "isaac_random_generator_core_defines.svh"
module isaac_ctrl #(
  parameter int unsigned MEM_WORDS = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire isaac_pkg::dp_stat_t          stat,
  output      isaac_pkg::ctl_cmd_t          cmd,
  output      logic [$clog2(MEM_WORDS)-1:0] idx
);
  import isaac_pkg::*;

  localparam int unsigned AW = $clog2(MEM_WORDS);

  typedef enum logic [4:0] {
    CLR, IDLE, DISPATCH, INIT_MIX0, INIT_RD, INIT_ADD, INIT_MIX, INIT_WR,
    G_START, G_RDX, G_PART, G_ADDX, G_Y, G_RDY, G_RES, N_RD, N_OUT
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [2:0]    step_r, step_nxt;
  logic [1:0]    rnd_r, rnd_nxt;
  logic          pass_r, pass_nxt;
  logic          gen_next_r, gen_next_nxt;
  logic          grp_end;
  logic          all_end;

  assign grp_end  = &cnt_r[2:0];
  assign all_end  = &cnt_r;
  assign in_ready = (state_r == IDLE);
  assign idx      = cnt_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    step_nxt     = step_r;
    rnd_nxt      = rnd_r;
    pass_nxt     = pass_r;
    gen_next_nxt = gen_next_r;
    cmd          = '0;
    cmd.mem_rsel = MRD_IDX;
    cmd.mix_step = step_r;
    case (state_r)
      CLR: begin
        cmd.clear = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (all_end) begin
          state_nxt = IDLE;
        end
      end
      IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = DISPATCH;
        end
      end
      DISPATCH: begin
        case (stat.op)
          OP_SEED: begin
            cmd.seed_wr = 1'b1;
            state_nxt   = IDLE;
          end
          OP_INIT: begin
            cmd.v_init = 1'b1;
            step_nxt   = '0;
            rnd_nxt    = '0;
            state_nxt  = INIT_MIX0;
          end
          OP_NEXT: begin
            if (stat.wl_zero) begin
              gen_next_nxt = 1'b1;
              state_nxt    = G_START;
            end else begin
              cmd.wl_dec = 1'b1;
              state_nxt  = N_RD;
            end
          end
          default: begin
            gen_next_nxt = 1'b0;
            state_nxt    = G_START;
          end
        endcase
      end
      INIT_MIX0: begin
        cmd.v_mix = 1'b1;
        step_nxt  = step_r + 3'd1;
        if (&step_r) begin
          rnd_nxt = rnd_r + 2'd1;
          if (&rnd_r) begin
            cnt_nxt   = '0;
            pass_nxt  = 1'b0;
            state_nxt = stat.mix_seed ? INIT_RD : INIT_MIX;
          end
        end
      end
      INIT_RD: begin
        state_nxt = INIT_ADD;
      end
      INIT_ADD: begin
        cmd.v_add     = 1'b1;
        cmd.v_add_res = !pass_r;
        cnt_nxt       = {cnt_r[AW-1:3], cnt_r[2:0] + 3'd1};
        state_nxt     = grp_end ? INIT_MIX : INIT_RD;
      end
      INIT_MIX: begin
        cmd.v_mix = 1'b1;
        step_nxt  = step_r + 3'd1;
        if (&step_r) begin
          state_nxt = INIT_WR;
        end
      end
      INIT_WR: begin
        cmd.v_write = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (grp_end) begin
          if (all_end) begin
            if (stat.mix_seed && !pass_r) begin
              pass_nxt  = 1'b1;
              state_nxt = INIT_RD;
            end else begin
              gen_next_nxt = 1'b0;
              state_nxt    = G_START;
            end
          end else begin
            state_nxt = stat.mix_seed ? INIT_RD : INIT_MIX;
          end
        end
      end
      G_START: begin
        cmd.gen_start = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = G_RDX;
      end
      G_RDX: begin
        cmd.acc_shift = 1'b1;
        state_nxt     = G_PART;
      end
      G_PART: begin
        cmd.x_load   = 1'b1;
        cmd.mem_rsel = MRD_PART;
        state_nxt    = G_ADDX;
      end
      G_ADDX: begin
        cmd.acc_add  = 1'b1;
        cmd.mem_rsel = MRD_X;
        state_nxt    = G_Y;
      end
      G_Y: begin
        cmd.y_write = 1'b1;
        state_nxt   = G_RDY;
      end
      G_RDY: begin
        cmd.mem_rsel = MRD_Y;
        state_nxt    = G_RES;
      end
      G_RES: begin
        cmd.res_gen = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (all_end) begin
          cmd.wl_full = 1'b1;
          cmd.wl_dec  = gen_next_r;
          state_nxt   = gen_next_r ? N_RD : IDLE;
        end else begin
          state_nxt = G_RDX;
        end
      end
      N_RD: begin
        cmd.res_rd_wl = 1'b1;
        state_nxt     = N_OUT;
      end
      N_OUT: begin
        cmd.res_rd_wl = 1'b1;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = IDLE;
        end
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= CLR;
      cnt_r      <= '0;
      step_r     <= '0;
      rnd_r      <= '0;
      pass_r     <= 1'b0;
      gen_next_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      step_r     <= step_nxt;
      rnd_r      <= rnd_nxt;
      pass_r     <= pass_nxt;
      gen_next_r <= gen_next_nxt;
    end
  end

  `ISAAC_ASSERT_NEXT(a_gen_end, (state_r == G_RES) && all_end, (state_r == N_RD) || (state_r == IDLE), "block end did not leave generation")
  `ISAAC_ASSERT_NEXT(a_seed_done, (state_r == DISPATCH) && (stat.op == OP_SEED), state_r == IDLE, "seed write did not finish in one cycle")
  `ISAAC_ASSERT_NEXT(a_grp_mix, (state_r == INIT_ADD) && grp_end, (state_r == INIT_MIX) && (step_r == 3'd0), "group add did not lead to a fresh mix")

endmodule
`default_nettype wire

/* sv/isaac_dp.sv */
// Datapath: memories, mix registers, accumulator and output register.
`default_nettype none
`include "isaac_random_generator_core_defines.svh"
module isaac_dp #(
  parameter int unsigned MEM_WORDS = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire isaac_pkg::ctl_cmd_t          cmd,
  input  wire logic [$clog2(MEM_WORDS)-1:0] idx,
  output      isaac_pkg::dp_stat_t          stat,
  input  wire logic [1:0]                   in_op,
  input  wire logic [31:0]                  in_seed_word,
  input  wire logic [7:0]                   in_seed_index,
  input  wire logic                         in_mix_seed,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      logic [31:0]                  out_rand_word
);
  import isaac_pkg::*;

  localparam int unsigned AW = $clog2(MEM_WORDS);

  op_t              op_r;
  logic [31:0]      seed_word_r;
  logic [7:0]       seed_index_r;
  logic             mix_seed_r;
  logic [7:0][31:0] v_r, v_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic [31:0]      last_r, last_nxt;
  logic [31:0]      cc_r;
  logic [AW:0]      wl_r, wl_nxt;
  logic [31:0]      x_r;
  logic [31:0]      y_r;
  logic [31:0]      y;
  logic [31:0]      acc_sh;
  logic             out_valid_r;
  logic [31:0]      out_word_r;
  logic             seed_ok;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [31:0]      mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [31:0]      mem_rdata;
  logic             res_we;
  logic [AW-1:0]    res_waddr;
  logic [31:0]      res_wdata;
  logic [AW-1:0]    res_raddr;
  logic [31:0]      res_rdata;

  assign seed_ok = (32'(seed_index_r) < 32'(MEM_WORDS));
  assign y       = mem_rdata + acc_r + last_r;

  always_comb begin
    case (cmd.mem_rsel)
      MRD_IDX:  mem_raddr = idx;
      MRD_PART: mem_raddr = {~idx[AW-1], idx[AW-2:0]};
      MRD_X:    mem_raddr = x_r[2 +: AW];
      MRD_Y:    mem_raddr = y_r[10 +: AW];
      default:  mem_raddr = idx;
    endcase
  end

  assign res_raddr = cmd.res_rd_wl ? wl_r[AW-1:0] : idx;

  assign mem_we    = cmd.clear | cmd.v_write | cmd.y_write;
  assign mem_waddr = idx;
  assign mem_wdata = cmd.clear ? '0 : (cmd.v_write ? v_r[idx[2:0]] : y);

  assign res_we    = cmd.clear | (cmd.seed_wr & seed_ok) | cmd.res_gen;
  assign res_waddr = cmd.seed_wr ? AW'(seed_index_r) : idx;
  assign res_wdata = cmd.clear ? '0 : (cmd.seed_wr ? seed_word_r : last_nxt);

  isaac_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  isaac_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_res (
    .clk   (clk),
    .we    (res_we),
    .waddr (res_waddr),
    .wdata (res_wdata),
    .raddr (res_raddr),
    .rdata (res_rdata)
  );

  always_comb begin
    v_nxt = v_r;
    if (cmd.v_init) begin
      v_nxt = {8{GOLDEN_RATIO}};
    end else if (cmd.v_mix) begin
      v_nxt = mix_line(v_r, cmd.mix_step);
    end else if (cmd.v_add) begin
      v_nxt[idx[2:0]] = v_r[idx[2:0]] + (cmd.v_add_res ? res_rdata : mem_rdata);
    end
  end

  // Shift amount and direction follow the word's position within four.
  always_comb begin
    case (idx[1:0])
      2'd0:    acc_sh = acc_r ^ (acc_r << 13);
      2'd1:    acc_sh = acc_r ^ (acc_r >> 6);
      2'd2:    acc_sh = acc_r ^ (acc_r << 2);
      default: acc_sh = acc_r ^ (acc_r >> 16);
    endcase
  end

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.acc_shift) begin
      acc_nxt = acc_sh;
    end else if (cmd.acc_add) begin
      acc_nxt = acc_r + mem_rdata;
    end
  end

  always_comb begin
    last_nxt = last_r;
    if (cmd.gen_start) begin
      last_nxt = last_r + cc_r + 32'd1;
    end else if (cmd.res_gen) begin
      last_nxt = mem_rdata + x_r;
    end
  end

  always_comb begin
    wl_nxt = wl_r;
    if (cmd.wl_full) begin
      wl_nxt = cmd.wl_dec ? (AW+1)'(MEM_WORDS - 1) : (AW+1)'(MEM_WORDS);
    end else if (cmd.wl_dec) begin
      wl_nxt = wl_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      last_r      <= '0;
      cc_r        <= '0;
      wl_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      last_r <= last_nxt;
      wl_r   <= wl_nxt;
      if (cmd.gen_start) begin
        cc_r <= cc_r + 32'd1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    if (cmd.latch_in) begin
      op_r         <= op_t'(in_op);
      seed_word_r  <= in_seed_word;
      seed_index_r <= in_seed_index;
      mix_seed_r   <= in_mix_seed;
    end
    if (cmd.x_load) begin
      x_r <= mem_rdata;
    end
    if (cmd.y_write) begin
      y_r <= y;
    end
    if (cmd.out_load) begin
      out_word_r <= res_rdata;
    end
  end

  assign stat.op       = op_r;
  assign stat.mix_seed = mix_seed_r;
  assign stat.wl_zero  = (wl_r == '0);
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_rand_word = out_word_r;

  `ISAAC_ASSERT(a_wl_range, wl_r <= (AW+1)'(MEM_WORDS), "words left exceeds block size")
  `ISAAC_ASSERT(a_load_free, cmd.out_load |-> (!out_valid_r || out_ready), "result overwritten before transaction")
  `ISAAC_ASSERT_NEXT(a_load_valid, cmd.out_load, out_valid_r, "loaded result not presented")

endmodule
`default_nettype wire

/* sv/isaac_random_generator_core.sv */
// Block generation makes four reads a word through the one RAM read port.
// Initialize: a first mix, then a mix and a write per group of 8 words (two passes with seed), then a block.
// Throughput: one transaction at a time; a result may wait while the next is taken.
// Reset: synchronous, active low; both memories are then cleared word by word,
// during which no transaction is taken.
`default_nettype none
module isaac_random_generator_core #(
  parameter int unsigned MEM_WORDS = isaac_pkg::MEM_WORDS_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  isaac_in_if.sink   in_chan,
  isaac_out_if.source out_chan
);
  import isaac_pkg::*;

  localparam int unsigned AW = $clog2(MEM_WORDS);

  ctl_cmd_t      cmd;
  dp_stat_t      stat;
  logic [AW-1:0] idx;

  isaac_ctrl #(.MEM_WORDS(MEM_WORDS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd),
    .idx      (idx)
  );

  isaac_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .idx           (idx),
    .stat          (stat),
    .in_op         (in_chan.op),
    .in_seed_word  (in_chan.seed_word),
    .in_seed_index (in_chan.seed_index),
    .in_mix_seed   (in_chan.mix_seed),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .out_rand_word (out_chan.rand_word)
  );

endmodule
`default_nettype wire
